FILE: rtl/sitda_pkg.sv
// Shared constants and types for the signed integer to decimal ASCII converter.
// Used by sitda_dabble and by the top level signed_int_to_decimal_ascii.
`timescale 1ns / 1ps
package sitda_pkg;

   localparam int WordWidth       = 32;
   localparam int DigitCount      = 10;
   localparam int DigitWidth      = 4;
   localparam int BcdWidth        = DigitCount * DigitWidth;
   localparam int BitsPerStep     = 4;
   localparam int StepCount       = WordWidth / BitsPerStep;
   localparam int StepCountWidth  = $clog2(StepCount);
   localparam int DigitIndexWidth = $clog2(DigitCount);
   localparam int CharWidth       = 8;

   localparam logic [CharWidth-1:0] AsciiZero  = 8'h30;
   localparam logic [CharWidth-1:0] AsciiMinus = 8'h2D;

   // Handshake between the sequencer and the conversion unit.
   typedef struct packed {
      logic busy;
      logic done;
   } dabble_status_type;

endpackage

FILE: rtl/sitda_dabble.sv
// Iterative binary to BCD conversion unit (shift and add-3), four bits per cycle.
// Depends on sitda_pkg for widths and the status struct.
`timescale 1ns / 1ps
module sitda_dabble (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [sitda_pkg::WordWidth-1:0]  operand,
   output sitda_pkg::dabble_status_type     status,
   output logic [sitda_pkg::BcdWidth-1:0]   bcd
);
   import sitda_pkg::*;

   logic [WordWidth-1:0]      shift_ff, shift_in;
   logic [BcdWidth-1:0]       bcd_ff, bcd_in;
   logic [StepCountWidth-1:0] count_ff, count_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [WordWidth-1:0]      shift_next;
   logic [BcdWidth-1:0]       bcd_next;

   // One step of the unit: correct every digit that is five or more, then
   // shift one binary bit in, repeated for each bit of the step.
   always_comb begin
      shift_next = shift_ff;
      bcd_next   = bcd_ff;
      for (int s = 0; s < BitsPerStep; s++) begin
         for (int n = 0; n < DigitCount; n++) begin
            if (bcd_next[n*DigitWidth +: DigitWidth] >= 4'd5) begin
               bcd_next[n*DigitWidth +: DigitWidth] =
                  bcd_next[n*DigitWidth +: DigitWidth] + 4'd3;
            end
         end
         bcd_next   = {bcd_next[BcdWidth-2:0], shift_next[WordWidth-1]};
         shift_next = {shift_next[WordWidth-2:0], 1'b0};
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = operand;
         bcd_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_next;
         bcd_in   = bcd_next;
         count_in = count_ff + 1'b1;
         if (count_ff == StepCountWidth'(StepCount - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign bcd         = bcd_ff;

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// Flow: the request is accepted, the shift-and-add-3 unit runs 8 steps, its done flag is
// registered, the sequencer picks the leading digit, and the first character is then
// loaded into the output register. The text leaves one character per cycle while the
// receiver is ready, 1 to 11 characters. A new request is taken only after the last
// character of the previous number has entered the output register.
// Reset (synchronous, active high) clears all control state.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sitda_pkg::WordWidth-1:0]  req_tdata,   // [31:0] value, signed
   // Result channel, one character per transfer.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sitda_pkg::CharWidth-1:0]  rsp_tdata,   // [7:0] character
   output logic                             rsp_tlast    // last
);
   import sitda_pkg::*;

   // Sequencer states.
   localparam logic [1:0] StIdle    = 2'd0;
   localparam logic [1:0] StConvert = 2'd1;
   localparam logic [1:0] StEmit    = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic                       sign_ff, sign_in;
   logic [DigitIndexWidth-1:0] pos_ff, pos_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]       rsp_char_ff, rsp_char_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       accept;
   logic                       negative;
   logic [WordWidth-1:0]       magnitude;
   dabble_status_type          dabble_status;
   logic [BcdWidth-1:0]        bcd;
   logic [DigitWidth-1:0]      digits [DigitCount];
   logic [DigitIndexWidth-1:0] top_digit;
   logic                       out_free;

   // The request is taken only while the sequencer is idle and the conversion
   // unit is free. The output register may still hold the last character of
   // the previous number.
   assign req_tready = (state_ff == StIdle) && !dabble_status.busy;
   assign accept     = req_tvalid && req_tready;

   // The magnitude is formed in unsigned arithmetic, so the most negative
   // value becomes 2147483648 rather than overflowing.
   assign negative  = req_tdata[WordWidth-1];
   assign magnitude = negative ? (WordWidth'(0) - req_tdata) : req_tdata;

   sitda_dabble u_dabble (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .operand (magnitude),
      .status  (dabble_status),
      .bcd     (bcd)
   );

   // Split the BCD word into digits and find the most significant nonzero
   // one. When every digit is zero the text is the single digit zero.
   always_comb begin
      top_digit = '0;
      for (int i = 0; i < DigitCount; i++) begin
         digits[i] = bcd[i*DigitWidth +: DigitWidth];
         if (digits[i] != '0) begin
            top_digit = DigitIndexWidth'(i);
         end
      end
   end

   // The output register can take a new character when it is empty or its
   // current character is being taken in this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      sign_in      = sign_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               sign_in  = negative;
               state_in = StConvert;
            end
         end
         StConvert: begin
            if (dabble_status.done) begin
               pos_in   = top_digit;
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  // The minus sign goes first and is never the last character.
                  rsp_char_in = AsciiMinus;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  rsp_char_in = AsciiZero + CharWidth'(digits[pos_ff]);
                  rsp_last_in = (pos_ff == '0);
                  if (pos_ff == '0) begin
                     state_in = StIdle;
                  end else begin
                     pos_in = pos_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         sign_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sign_ff      <= sign_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: bench/signed_int_to_decimal_ascii_tb.sv
// Self-checking bench for signed_int_to_decimal_ascii: drives signed 32-bit requests
// and checks every character of the decimal text against a local predictor.
// Depends on sitda_pkg and the RTL of signed_int_to_decimal_ascii.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_tb;
   import sitda_pkg::*;

   // Generous ceiling on the run. The slowest correct run is roughly 350 requests,
   // each with a sender idle burst, the block's own work and a receiver stall on
   // every character, plus the long hold-off.
   localparam int CycleLimit   = 400000;
   localparam int LongHoldOff  = 300;
   localparam int DrainCycles  = 40;

   typedef struct packed {
      logic [CharWidth-1:0] character;
      logic                 last;
   } text_char_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [WordWidth-1:0] req_tdata = '0;  // [31:0] value, signed
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [CharWidth-1:0] rsp_tdata;       // [7:0] character
   logic                 rsp_tlast;       // last

   // Characters still owed by the block, oldest first.
   text_char_type pending_text [$];

   int  error_count      = 0;
   int  cycle_count      = 0;
   int  requests_sent    = 0;
   int  chars_checked    = 0;
   int  negatives_sent   = 0;
   bit  sender_idles     = 1'b1;
   bit  receiver_idles   = 1'b1;
   bit  long_hold_wanted = 1'b0;

   signed_int_to_decimal_ascii DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog. A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[signed_int_to_decimal_ascii] ERROR");
         $finish;
      end
   end

   // Predictor. It forms the magnitude as an unsigned word, so the most negative
   // value needs no special path. Then it emits an optional minus sign and the
   // digits, most significant first. Only the final digit carries last.
   function automatic void push_decimal_text(input logic [WordWidth-1:0] value);
      logic                 negative;
      logic [WordWidth-1:0] magnitude;
      logic [3:0]           digits [DigitCount];
      int                   digit_total;
      text_char_type        entry;
      negative    = value[WordWidth-1];
      magnitude   = negative ? (32'd0 - value) : value;
      digit_total = 0;
      do begin
         digits[digit_total] = 4'(magnitude % 10);
         digit_total++;
         magnitude = magnitude / 10;
      end while (magnitude != 0 && digit_total < DigitCount);
      if (negative) begin
         entry.character = AsciiMinus;
         entry.last      = 1'b0;
         pending_text.push_back(entry);
      end
      for (int k = digit_total; k > 0; k--) begin
         entry.character = AsciiZero + CharWidth'(digits[k-1]);
         entry.last      = (k == 1);
         pending_text.push_back(entry);
      end
   endfunction

   // Offers one request and returns at the rising edge that accepted it. The
   // handshake is sampled at the falling edge, where every signal is settled.
   // The optional idle burst lowers tvalid and puts junk on tdata. The block
   // must ignore that junk.
   task automatic send_request(input logic [WordWidth-1:0] value);
      bit taken;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      push_decimal_text(value);
      requests_sent++;
      if (value[WordWidth-1]) negatives_sent++;
   endtask

   // Random value with an evenly spread digit count. A flat random word would
   // almost always have ten digits. Negative magnitudes may reach 2^31.
   function automatic logic [WordWidth-1:0] random_decimal_value();
      int     digit_len;
      longint low_bound;
      longint span;
      longint magnitude;
      bit     negative;
      digit_len = $urandom_range(1, DigitCount);
      low_bound = 1;
      for (int i = 1; i < digit_len; i++) low_bound = low_bound * 10;
      if (digit_len == 1) low_bound = 0;
      span      = (digit_len == 1) ? 10 :
                  (digit_len == DigitCount) ? 64'd2147483649 - low_bound : low_bound * 9;
      magnitude = low_bound + (longint'($urandom) % span);
      negative  = $urandom_range(0, 1);
      if (!negative && magnitude > 64'd2147483647) magnitude = 64'd2147483647;
      return negative ? WordWidth'(-magnitude) : WordWidth'(magnitude);
   endfunction

   // Receiver. It stalls in random bursts. On request it holds off once for a
   // long stretch, counted here, so the block backs up into its input.
   initial begin
      forever begin
         if (long_hold_wanted) begin
            rsp_tready <= 1'b0;
            repeat (LongHoldOff) @(posedge clock);
            long_hold_wanted = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Checker. Every accepted character is compared with the oldest one predicted.
   always @(negedge clock) begin : check_text
      text_char_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_text.size() == 0) begin
            $error("unexpected character %h (last %b) with nothing pending",
                   rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            wanted = pending_text.pop_front();
            chars_checked++;
            if (rsp_tdata !== wanted.character) begin
               $error("character: expected %h, got %h", wanted.character, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== wanted.last) begin
               $error("last: expected %b, got %b", wanted.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Boundary values: zero, one-digit values, the power-of-ten crossings at 10, 100
   // and 10^9, both ends of the range, and alternating bit patterns.
   task automatic test_corner_values();
      logic [WordWidth-1:0] corners [0:21];
      corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                  32'd100, -32'sd9, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFE,
                  32'h8000_0001, 32'd999999999, 32'd1000000000, -32'sd1000000000,
                  32'd1999999999, 32'h5555_5555, 32'hAAAA_AAAA, 32'd12345,
                  -32'sd12345, 32'd1000000001};
      foreach (corners[i]) send_request(corners[i]);
   endtask

   // Mostly digit-count-spread values, plus a share of raw random words so that
   // every input bit is toggled.
   task automatic test_random_values(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) send_request($urandom);
         else send_request(random_decimal_value());
      end
   endtask

   // The receiver goes quiet for a long stretch while requests keep coming, so
   // the block must stop taking requests. No request may be lost.
   task automatic test_output_backpressure();
      long_hold_wanted = 1'b1;
      test_random_values(40);
   endtask

   // Back-to-back traffic with both sides always ready.
   task automatic test_full_rate();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      test_random_values(120);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_values();
      test_random_values(170);
      test_output_backpressure();
      test_full_rate();

      req_tvalid <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
      // Let any stray extra character surface before the verdict.
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d values (%0d negative), checked %0d characters.",
               requests_sent, negatives_sent, chars_checked);
      $display("Covered zero, both range ends, random stalls, a long output stall, full rate.");
      if (error_count == 0) begin
         $display("[signed_int_to_decimal_ascii] OK");
      end else begin
         $display("[signed_int_to_decimal_ascii] ERROR");
      end
      $finish;
   end

endmodule
